// File: rtl/fddf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddf_pkg
// Shared types, codes and constants of the frequency display digit formatter.
// ----------------------------------------------------------------------------
package fddf_pkg;

   localparam int unsigned NUM_W    = 24;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned DIGITS   = 7;
   localparam int unsigned DIGIT_W  = 4;
   localparam int unsigned RECIP_W  = NUM_W + 1;
   localparam int unsigned PROD_W   = NUM_W + RECIP_W;

   localparam logic [NUM_W-1:0]   MAX_NUMBER = NUM_W'(9999999);
   localparam logic [DIGIT_W-1:0] BLANK      = DIGIT_W'(15);
   localparam logic [CODE_W-1:0]  BLANK_CODE = CODE_W'(15);

   // csr map
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_INDEX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_INDEX = CSR_INDEX_W'(0);

   // mode codes and the symbols they select
   localparam logic [CODE_W-1:0] MODE_ONE  = CODE_W'(1);
   localparam logic [CODE_W-1:0] MODE_TWO  = CODE_W'(2);
   localparam logic [CODE_W-1:0] MODE_CHAN = CODE_W'(3);
   localparam logic [CODE_W-1:0] MODE_HOLD = CODE_W'(5);
   localparam logic [CODE_W-1:0] SYM_ONE   = CODE_W'(1);
   localparam logic [CODE_W-1:0] SYM_TWO   = CODE_W'(12);
   localparam logic [CODE_W-1:0] SYM_CHAN  = CODE_W'(2);

   // digit placement formats
   localparam logic [CODE_W-1:0] FMT_WIDE       = CODE_W'(0);
   localparam logic [CODE_W-1:0] FMT_SHIFT      = CODE_W'(1);
   localparam logic [CODE_W-1:0] FMT_REGION     = CODE_W'(2);
   localparam logic [CODE_W-1:0] FMT_OFS_NEG    = CODE_W'(3);
   localparam logic [CODE_W-1:0] FMT_OFS_POS    = CODE_W'(4);
   localparam logic [CODE_W-1:0] FMT_OFS_ZERO   = CODE_W'(5);
   localparam logic [CODE_W-1:0] FMT_WIDE_ALT   = CODE_W'(9);
   localparam logic [CODE_W-1:0] FMT_SHIFT_ALT  = CODE_W'(10);
   localparam logic [CODE_W-1:0] FMT_TUNE_0     = CODE_W'(11);
   localparam logic [CODE_W-1:0] FMT_TUNE_1     = CODE_W'(12);
   localparam logic [CODE_W-1:0] FMT_TUNE_2     = CODE_W'(13);
   localparam logic [CODE_W-1:0] FMT_TUNE_3     = CODE_W'(14);
   localparam logic [CODE_W-1:0] FMT_TUNE_4     = CODE_W'(15);
   localparam logic [CODE_W-1:0] FMT_TUNE_5     = CODE_W'(16);
   localparam logic [CODE_W-1:0] FMT_SHIFT_TAIL = CODE_W'(17);
   localparam logic [CODE_W-1:0] FMT_BLANK_LIM  = CODE_W'(3);

   // reciprocals for floor(n / 10^k), exact for any NUM_W-bit n
   localparam int unsigned DIV_SHIFT [DIGITS] = '{0, 28, 31, 34, 38, 41, 44};
   localparam logic [RECIP_W-1:0] DIV_RECIP [DIGITS] = '{
      RECIP_W'(1),
      RECIP_W'(((64'd1 << 28) + 64'd9) / 64'd10),
      RECIP_W'(((64'd1 << 31) + 64'd99) / 64'd100),
      RECIP_W'(((64'd1 << 34) + 64'd999) / 64'd1000),
      RECIP_W'(((64'd1 << 38) + 64'd9999) / 64'd10000),
      RECIP_W'(((64'd1 << 41) + 64'd99999) / 64'd100000),
      RECIP_W'(((64'd1 << 44) + 64'd999999) / 64'd1000000)
   };

   // decimal digits, units first
   typedef logic [DIGITS-1:0][DIGIT_W-1:0] digits_type;

   typedef struct packed {
      logic [CODE_W-1:0]  d0;
      logic [CODE_W-1:0]  d1;
      logic [DIGIT_W-1:0] d2;
      logic [DIGIT_W-1:0] d3;
      logic [DIGIT_W-1:0] d4;
      logic [DIGIT_W-1:0] d5;
   } positions_type;

endpackage

// File: rtl/fddf_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddf_csr
// Register port holding the band region number.
// ----------------------------------------------------------------------------
module fddf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fddf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fddf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fddf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [fddf_pkg::CODE_W-1:0]        region_index
);
   import fddf_pkg::*;

   logic [CODE_W-1:0]      region_ff;
   logic [CODE_W-1:0]      region_in;
   logic [CSR_INDEX_W-1:0] reg_sel;
   logic                   wr_en;

   assign reg_sel = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready && (reg_sel == REG_REGION_INDEX);

   assign region_in = wr_en ? pwdata[CODE_W-1:0] : region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= '0;
      end else begin
         region_ff <= region_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel == REG_REGION_INDEX) begin
         prdata = {{(CSR_DATA_W-CODE_W){1'b0}}, region_ff};
      end
   end

   assign region_index = region_ff;

endmodule

// File: rtl/fddf_digit_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddf_digit_split
// Splits a binary value into decimal digits by reciprocal multiplication,
// with optional leading zero blanking.
// ----------------------------------------------------------------------------
module fddf_digit_split (
   input  logic [fddf_pkg::NUM_W-1:0] number,
   input  logic                       blank_en,
   output fddf_pkg::digits_type       digits
);
   import fddf_pkg::*;

   logic [PROD_W-1:0] prod  [DIGITS];
   logic [NUM_W-1:0]  quot  [DIGITS];
   logic [DIGIT_W-1:0] ten_q [DIGITS];

   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         prod[k] = PROD_W'(number) * PROD_W'(DIV_RECIP[k]);
         quot[k] = NUM_W'(prod[k] >> DIV_SHIFT[k]);
      end
      // digit k = q_k - 10 q_(k+1), exact in four bits
      for (int k = 0; k < DIGITS; k++) begin
         if (k == DIGITS - 1) begin
            ten_q[k] = '0;
         end else begin
            ten_q[k] = DIGIT_W'({quot[k+1][DIGIT_W-1:0], 3'b000})
                     + DIGIT_W'({quot[k+1][DIGIT_W-1:0], 1'b0});
         end
         digits[k] = quot[k][DIGIT_W-1:0] - ten_q[k];
         // leading zero: value below 10^k means quotient is zero
         if (blank_en && (k != 0) && (quot[k] == '0)) begin
            digits[k] = BLANK;
         end
      end
   end

endmodule

// File: rtl/fddf_placer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fddf_placer
// Places decimal digits into the six display positions by format code.
// ----------------------------------------------------------------------------
module fddf_placer (
   input  logic [fddf_pkg::CODE_W-1:0] format_code,
   input  fddf_pkg::digits_type        digits,
   input  logic [fddf_pkg::CODE_W-1:0] region_index,
   output fddf_pkg::positions_type     positions
);
   import fddf_pkg::*;

   function automatic logic [CODE_W-1:0] widen(input logic [DIGIT_W-1:0] d);
      widen = {{(CODE_W-DIGIT_W){1'b0}}, d};
   endfunction

   always_comb begin
      // default: millions through tens
      positions.d0 = widen(digits[6]);
      positions.d1 = widen(digits[5]);
      positions.d2 = digits[4];
      positions.d3 = digits[3];
      positions.d4 = digits[2];
      positions.d5 = digits[1];
      case (format_code)
         FMT_SHIFT, FMT_SHIFT_ALT, FMT_SHIFT_TAIL: begin
            positions.d0 = widen(digits[5]);
            positions.d1 = widen(digits[4]);
            positions.d2 = digits[3];
            positions.d3 = digits[2];
            positions.d4 = digits[1];
            positions.d5 = (format_code == FMT_SHIFT_TAIL) ? BLANK : digits[0];
         end
         FMT_REGION: begin
            positions.d0 = BLANK_CODE;
            positions.d1 = region_index + CODE_W'(1);
            positions.d2 = BLANK;
            positions.d3 = digits[1];
            positions.d4 = digits[0];
            positions.d5 = BLANK;
         end
         FMT_OFS_NEG: begin
            positions.d0 = widen(digits[3]);
            positions.d1 = widen(digits[2]);
            positions.d2 = digits[1];
            positions.d3 = digits[0];
            positions.d4 = BLANK;
            positions.d5 = BLANK;
         end
         FMT_OFS_POS: begin
            positions.d0 = BLANK_CODE;
            positions.d1 = BLANK_CODE;
            positions.d2 = digits[3];
            positions.d3 = digits[2];
            positions.d4 = digits[1];
            positions.d5 = digits[0];
         end
         FMT_OFS_ZERO: begin
            positions.d0 = BLANK_CODE;
            positions.d1 = '0;
            positions.d2 = '0;
            positions.d3 = '0;
            positions.d4 = '0;
            positions.d5 = BLANK;
         end
         FMT_TUNE_0: positions.d0 = BLANK_CODE;
         FMT_TUNE_1: positions.d1 = BLANK_CODE;
         FMT_TUNE_2: positions.d2 = BLANK;
         FMT_TUNE_3: positions.d3 = BLANK;
         FMT_TUNE_4: positions.d4 = BLANK;
         FMT_TUNE_5: positions.d5 = BLANK;
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/frequency_display_digit_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_display_digit_formatter
// Formats one display update into mode, grid, six digit and channel positions.
// ----------------------------------------------------------------------------
// One request enters per clock cycle while the result register is not stalled:
// the request is captured in an input register, then a single pass through the
// reciprocal multipliers of the digit split, the placement mux and the mode
// decode feeds the result register. The throughput of one request per cycle
// is set by that single pass; a stalled result register holds one result while
// the input register still takes one more request. The only state kept across
// requests is the mode symbol (reset to blank), which mode 5 leaves as it was.
// The region register at byte address 0 should be written while no request is
// in flight.
module frequency_display_digit_formatter (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fddf_pkg::CODE_W-1:0]        req_mode_code,
   input  logic [fddf_pkg::CODE_W-1:0]        req_status_grid,
   input  logic [fddf_pkg::NUM_W-1:0]         req_number,
   input  logic [fddf_pkg::CODE_W-1:0]        req_channel_symbol,
   input  logic [fddf_pkg::CODE_W-1:0]        req_format_code,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fddf_pkg::CODE_W-1:0]        rsp_pos_mode,
   output logic [fddf_pkg::DIGIT_W-1:0]       rsp_pos_grid,
   output logic [fddf_pkg::CODE_W-1:0]        rsp_pos_d0,
   output logic [fddf_pkg::CODE_W-1:0]        rsp_pos_d1,
   output logic [fddf_pkg::DIGIT_W-1:0]       rsp_pos_d2,
   output logic [fddf_pkg::DIGIT_W-1:0]       rsp_pos_d3,
   output logic [fddf_pkg::DIGIT_W-1:0]       rsp_pos_d4,
   output logic [fddf_pkg::DIGIT_W-1:0]       rsp_pos_d5,
   output logic [fddf_pkg::CODE_W-1:0]        rsp_pos_channel,
   // configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fddf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fddf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fddf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import fddf_pkg::*;

   // input register stage
   logic               s1_valid_ff, s1_valid_in;
   logic [CODE_W-1:0]  s1_mode_ff;
   logic [CODE_W-1:0]  s1_grid_ff;
   logic [NUM_W-1:0]   s1_num_ff;
   logic [CODE_W-1:0]  s1_chan_ff;
   logic [CODE_W-1:0]  s1_fmt_ff;

   // result register stage
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]  pos_mode_ff, pos_mode_in;
   logic [DIGIT_W-1:0] pos_grid_ff, pos_grid_in;
   positions_type      pos_ff, pos_in;
   logic [CODE_W-1:0]  pos_chan_ff, pos_chan_in;

   // kept across requests
   logic [CODE_W-1:0]  mode_symbol_ff;

   logic               req_take;
   logic               s1_advance;
   logic               out_free;
   logic [NUM_W-1:0]   num_sat;
   logic               chan_show;
   logic [CODE_W-1:0]  region_index;
   digits_type         digits;

   // handshake: result register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_take   = req_valid && req_ready;
   assign s1_advance = s1_valid_ff && out_free;

   assign s1_valid_in  = req_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // saturate on the way in so the digit split sees at most seven digits
   assign num_sat = (req_number > MAX_NUMBER) ? MAX_NUMBER : req_number;

   fddf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .region_index (region_index)
   );

   // leading zero blanking only in the first three formats
   fddf_digit_split u_split (
      .number   (s1_num_ff),
      .blank_en (s1_fmt_ff < FMT_BLANK_LIM),
      .digits   (digits)
   );

   fddf_placer u_placer (
      .format_code  (s1_fmt_ff),
      .digits       (digits),
      .region_index (region_index),
      .positions    (pos_in)
   );

   // mode decode; hold mode keeps the stored symbol
   always_comb begin
      chan_show = 1'b0;
      case (s1_mode_ff)
         MODE_ONE:  pos_mode_in = SYM_ONE;
         MODE_TWO:  pos_mode_in = SYM_TWO;
         MODE_CHAN: begin
            pos_mode_in = SYM_CHAN;
            chan_show   = 1'b1;
         end
         MODE_HOLD: begin
            pos_mode_in = mode_symbol_ff;
            chan_show   = 1'b1;
         end
         default:   pos_mode_in = BLANK_CODE;
      endcase
   end

   assign pos_chan_in = chan_show ? s1_chan_ff : BLANK_CODE;

   // status grid clamps to blank above fifteen
   assign pos_grid_in = (s1_grid_ff > CODE_W'(BLANK)) ? BLANK : s1_grid_ff[DIGIT_W-1:0];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mode_symbol_ff <= BLANK_CODE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_advance) begin
            mode_symbol_ff <= pos_mode_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_mode_code;
         s1_grid_ff <= req_status_grid;
         s1_num_ff  <= num_sat;
         s1_chan_ff <= req_channel_symbol;
         s1_fmt_ff  <= req_format_code;
      end
      if (s1_advance) begin
         pos_mode_ff <= pos_mode_in;
         pos_grid_ff <= pos_grid_in;
         pos_ff      <= pos_in;
         pos_chan_ff <= pos_chan_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_mode    = pos_mode_ff;
   assign rsp_pos_grid    = pos_grid_ff;
   assign rsp_pos_d0      = pos_ff.d0;
   assign rsp_pos_d1      = pos_ff.d1;
   assign rsp_pos_d2      = pos_ff.d2;
   assign rsp_pos_d3      = pos_ff.d3;
   assign rsp_pos_d4      = pos_ff.d4;
   assign rsp_pos_d5      = pos_ff.d5;
   assign rsp_pos_channel = pos_chan_ff;

endmodule
